// ===== sv/pcn_pkg.sv =====
// ----------------------------------------------------------------------------
// pcn_pkg: shared types and constants for the point cloud normalizer
// Payload structs, command/status structs, state codes and saturation helper.
// ----------------------------------------------------------------------------
package pcn_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;

  localparam int COORD_W            = 32;
  localparam int FRAC_W             = 16;
  localparam int EXT_W              = COORD_W + 1;
  localparam int NUM_W              = COORD_W + FRAC_W;
  localparam int REM_W              = EXT_W + 1;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES         = NUM_W / DIV_BITS_PER_CYCLE;
  localparam int CFG_IDX_W          = 1;

  localparam logic signed [COORD_W-1:0] OFFSET_X_RESET = 32'sd32768;
  localparam logic signed [COORD_W-1:0] OFFSET_Y_RESET = 32'sd39322;
  localparam logic signed [COORD_W-1:0] SAT_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_LO = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 1'b0,
    REG_OFFSET_Y = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMPTY,
    S_READ,
    S_EXT,
    S_CHK,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      last_point;
    logic                      zero_extent;
    logic                      store_empty;
  } out_t;

  typedef struct packed {
    logic  load;
    logic  fetch;
    logic  set_empty;
    logic  capture;
    logic  ext_update;
    logic  set_zero;
    logic  div_start;
    logic  div_store;
    logic  advance;
    axis_t axis;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic ext_zero;
    logic div_done;
  } status_t;

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [COORD_W:0] sum;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      return sum[COORD_W] ? SAT_LO : SAT_HI;
    end
    return sum[COORD_W-1:0];
  endfunction

endpackage

// ===== sv/point_cloud_normalizer.sv =====
// ----------------------------------------------------------------------------
// point_cloud_normalizer: bounding-box uniform-scale normalization, Q16.16
// Load: taken while idle, no result; a new item may follow next cycle.
// Fetch: result strobed after three 48-bit divisions, two quotient bits a
// cycle, on one shared divider; sooner on zero extent, and in the cycle after
// the transfer on an empty store. Results cannot be stalled.
// Reset: offsets return to 0.5 and 0.6, the store empties.
// ----------------------------------------------------------------------------
module point_cloud_normalizer import pcn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  item,
  output logic                 done,
  output out_t                 result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data
);

  cmd_t    cmd;
  status_t status;

  pcn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pcn_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .item    (item),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .result  (result)
  );

endmodule

// ===== sv/pcn_ram.sv =====
// ----------------------------------------------------------------------------
// pcn_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pcn_div.sv =====
// ----------------------------------------------------------------------------
// pcn_div: iterative restoring divider with signed saturation
// Divides a magnitude by the extent two quotient bits a cycle, then applies
// the sign and saturates to 32 bits.
// ----------------------------------------------------------------------------
module pcn_div import pcn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      neg,
  input  logic [NUM_W-1:0]          num,
  input  logic [EXT_W-1:0]          den,
  output logic                      done,
  output logic signed [COORD_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_CYCLES + 1);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({(COORD_W-1){1'b1}});
  localparam logic [NUM_W-1:0] NEG_LIM = POS_LIM + NUM_W'(1);

  logic                      running;
  logic                      fin;
  logic [CNT_W-1:0]          cnt;
  logic [REM_W-1:0]          rem;
  logic [NUM_W-1:0]          acc;
  logic [EXT_W-1:0]          dvs;
  logic                      sign;
  logic [REM_W-1:0]          rem_next;
  logic [NUM_W-1:0]          acc_next;
  logic [REM_W-1:0]          trial;
  logic signed [COORD_W-1:0] quot_next;

  always_comb begin
    rem_next = rem;
    acc_next = acc;
    trial    = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial    = {rem_next[REM_W-2:0], acc_next[NUM_W-1]};
      acc_next = {acc_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = trial - {1'b0, dvs};
        acc_next[0] = 1'b1;
      end else begin
        rem_next = trial;
      end
    end
  end

  always_comb begin
    if (!sign) begin
      quot_next = (acc > POS_LIM) ? SAT_HI : acc[COORD_W-1:0];
    end else begin
      quot_next = (acc > NEG_LIM) ? SAT_LO : -acc[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_CYCLES);
      end else if (running) begin
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
        cnt <= cnt - CNT_W'(1);
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      acc  <= num;
      dvs  <= den;
      sign <= neg;
    end else if (running) begin
      rem <= rem_next;
      acc <= acc_next;
    end
    if (fin) begin
      quot <= quot_next;
    end
  end

endmodule

// ===== sv/pcn_dp.sv =====
// ----------------------------------------------------------------------------
// pcn_dp: point cloud normalizer datapath
// Point store, bounding box, extent, offsets, divider and result registers.
// ----------------------------------------------------------------------------
module pcn_dp import pcn_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  in_t                  item,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data,
  output out_t                 result
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PT_W   = 3 * COORD_W;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_POINTS);

  logic [CNT_W-1:0]          point_count;
  logic [CNT_W-1:0]          read_index;
  logic signed [COORD_W-1:0] min_x, min_y, min_z;
  logic signed [COORD_W-1:0] max_x, max_y, max_z;
  logic [EXT_W-1:0]          largest_extent;
  logic [EXT_W-1:0]          ext_x, ext_y, ext_z;
  logic [EXT_W-1:0]          ext_max;
  logic signed [COORD_W-1:0] pt_x, pt_y, pt_z;
  logic signed [COORD_W-1:0] offset_x, offset_y;
  logic signed [COORD_W-1:0] res_x, res_y, res_z;
  logic                      res_last, res_zero, res_empty;
  logic [PT_W-1:0]           rd_data;
  logic                      full;
  logic                      is_last;
  logic                      store_we;
  logic signed [COORD_W-1:0] div_coord;
  logic [COORD_W-1:0]        div_mag;
  logic [NUM_W-1:0]          div_num;
  logic                      div_done;
  logic signed [COORD_W-1:0] div_quot;

  function automatic logic [EXT_W-1:0] span(
    input logic signed [COORD_W-1:0] hi,
    input logic signed [COORD_W-1:0] lo
  );
    return {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
  endfunction

  assign full     = (point_count == CAPACITY);
  assign is_last  = ({1'b0, read_index} + (CNT_W+1)'(1)) >= {1'b0, point_count};
  assign store_we = cmd.load && !full;

  assign status.empty    = (point_count == '0) || (read_index >= point_count);
  assign status.ext_zero = (largest_extent == '0);
  assign status.div_done = div_done;

  pcn_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(point_count[ADDR_W-1:0]),
    .wdata({item.coord_x, item.coord_y, item.coord_z}),
    .re   (cmd.fetch),
    .raddr(read_index[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  always_comb begin
    if ((ext_x >= ext_y) && (ext_x >= ext_z)) begin
      ext_max = ext_x;
    end else if (ext_y >= ext_z) begin
      ext_max = ext_y;
    end else begin
      ext_max = ext_z;
    end
  end

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  div_coord = pt_x;
      AXIS_Y:  div_coord = pt_y;
      default: div_coord = pt_z;
    endcase
    div_mag = div_coord[COORD_W-1] ? (~div_coord + COORD_W'(1)) : div_coord;
    div_num = {div_mag, {FRAC_W{1'b0}}};
  end

  pcn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .neg  (div_coord[COORD_W-1]),
    .num  (div_num),
    .den  (largest_extent),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count    <= '0;
      read_index     <= '0;
      largest_extent <= '0;
      min_x          <= '0;
      min_y          <= '0;
      min_z          <= '0;
      max_x          <= '0;
      max_y          <= '0;
      max_z          <= '0;
      offset_x       <= OFFSET_X_RESET;
      offset_y       <= OFFSET_Y_RESET;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_OFFSET_X: offset_x <= wr_data;
          REG_OFFSET_Y: offset_y <= wr_data;
        endcase
      end
      if (store_we) begin
        if (point_count == '0) begin
          min_x <= item.coord_x;
          max_x <= item.coord_x;
          min_y <= item.coord_y;
          max_y <= item.coord_y;
          min_z <= item.coord_z;
          max_z <= item.coord_z;
        end else begin
          if (item.coord_x < min_x) min_x <= item.coord_x;
          if (item.coord_x > max_x) max_x <= item.coord_x;
          if (item.coord_y < min_y) min_y <= item.coord_y;
          if (item.coord_y > max_y) max_y <= item.coord_y;
          if (item.coord_z < min_z) min_z <= item.coord_z;
          if (item.coord_z > max_z) max_z <= item.coord_z;
        end
        point_count <= point_count + CNT_W'(1);
      end
      if (cmd.ext_update && (read_index == '0)) begin
        largest_extent <= ext_max;
      end
      if (cmd.advance) begin
        if (is_last) begin
          point_count    <= '0;
          read_index     <= '0;
          largest_extent <= '0;
          min_x          <= '0;
          min_y          <= '0;
          min_z          <= '0;
          max_x          <= '0;
          max_y          <= '0;
          max_z          <= '0;
        end else begin
          read_index <= read_index + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pt_x      <= rd_data[PT_W-1 -: COORD_W];
      pt_y      <= rd_data[2*COORD_W-1 -: COORD_W];
      pt_z      <= rd_data[COORD_W-1:0];
      ext_x     <= span(max_x, min_x);
      ext_y     <= span(max_y, min_y);
      ext_z     <= span(max_z, min_z);
      res_last  <= is_last;
      res_zero  <= 1'b0;
      res_empty <= 1'b0;
    end
    if (cmd.set_empty) begin
      res_x     <= '0;
      res_y     <= '0;
      res_z     <= '0;
      res_last  <= 1'b0;
      res_zero  <= 1'b0;
      res_empty <= 1'b1;
    end
    if (cmd.set_zero) begin
      res_x    <= offset_x;
      res_y    <= offset_y;
      res_z    <= '0;
      res_zero <= 1'b1;
    end
    if (cmd.div_store) begin
      unique case (cmd.axis)
        AXIS_X:  res_x <= sat_add(div_quot, offset_x);
        AXIS_Y:  res_y <= sat_add(div_quot, offset_y);
        default: res_z <= div_quot;
      endcase
    end
  end

  assign result.out_x       = res_x;
  assign result.out_y       = res_y;
  assign result.out_z       = res_z;
  assign result.last_point  = res_last;
  assign result.zero_extent = res_zero;
  assign result.store_empty = res_empty;

endmodule

// ===== sv/pcn_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcn_ctrl: point cloud normalizer controller
// Sequences loads, point reads, extent update and the three axis divisions.
// ----------------------------------------------------------------------------
module pcn_ctrl import pcn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    kind,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;
  axis_t  axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    busy       = (state != S_IDLE);
    done       = (state == S_OUT) || (state == S_EMPTY);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.fetch = 1'b1;
            if (status.empty) begin
              cmd.set_empty = 1'b1;
              state_next    = S_EMPTY;
            end else begin
              state_next = S_READ;
            end
          end
        end
      end
      S_EMPTY: state_next = S_IDLE;
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_EXT;
      end
      S_EXT: begin
        cmd.ext_update = 1'b1;
        state_next     = S_CHK;
      end
      S_CHK: begin
        if (status.ext_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_OUT;
        end else begin
          axis_next  = AXIS_X;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (axis == AXIS_Z) begin
            state_next = S_OUT;
          end else begin
            axis_next  = (axis == AXIS_X) ? AXIS_Y : AXIS_Z;
            state_next = S_START;
          end
        end
      end
      S_OUT: begin
        cmd.advance = 1'b1;
        state_next  = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/point_cloud_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// point_cloud_normalizer_test: self-checking bench for the cloud normalizer
// Loads point clouds, fetches them back and checks each normalized point
// against a bounding-box predictor kept in a scoreboard. Covers empty store,
// zero extent, saturation, loads while fetching and several offset settings,
// with random start gaps on the command side.
// ----------------------------------------------------------------------------
module point_cloud_normalizer_test import pcn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {SPREAD, NEAR_ORIGIN, CLUSTER, CORNERS, FIXED} coord_style_t;

  class cloud_scoreboard;
    logic signed [COORD_W-1:0] pts_x[MAX_POINTS_DEF];
    logic signed [COORD_W-1:0] pts_y[MAX_POINTS_DEF];
    logic signed [COORD_W-1:0] pts_z[MAX_POINTS_DEF];
    logic signed [COORD_W-1:0] off_x = OFFSET_X_RESET;
    logic signed [COORD_W-1:0] off_y = OFFSET_Y_RESET;
    longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    longint span;
    int stored;
    int next_idx;
    out_t due_points[$];
    int fails = 0;

    function new();
      clear_box();
    endfunction

    function void clear_box();
      lo_x = 0; lo_y = 0; lo_z = 0;
      hi_x = 0; hi_y = 0; hi_z = 0;
      span = 0;
      stored = 0;
      next_idx = 0;
    endfunction

    function void set_offset(reg_index_t idx, logic [COORD_W-1:0] v);
      if (idx == REG_OFFSET_X) begin
        off_x = v;
      end else begin
        off_y = v;
      end
    endfunction

    function logic signed [COORD_W-1:0] clip32(longint v);
      if (v > longint'(SAT_HI)) return SAT_HI;
      if (v < longint'(SAT_LO)) return SAT_LO;
      return v[COORD_W-1:0];
    endfunction

    function logic signed [COORD_W-1:0] scaled(logic signed [COORD_W-1:0] c);
      return clip32((longint'(c) * 65536) / span);
    endfunction

    function void note_item(in_t it);
      out_t r;
      int i;
      longint x, y, z;
      longint ex, ey, ez;
      x = longint'(it.coord_x);
      y = longint'(it.coord_y);
      z = longint'(it.coord_z);
      if (it.kind == KIND_LOAD) begin
        if (stored >= MAX_POINTS_DEF) return;
        pts_x[stored] = it.coord_x;
        pts_y[stored] = it.coord_y;
        pts_z[stored] = it.coord_z;
        if (stored == 0) begin
          lo_x = x; hi_x = x;
          lo_y = y; hi_y = y;
          lo_z = z; hi_z = z;
        end else begin
          if (x < lo_x) lo_x = x;
          if (x > hi_x) hi_x = x;
          if (y < lo_y) lo_y = y;
          if (y > hi_y) hi_y = y;
          if (z < lo_z) lo_z = z;
          if (z > hi_z) hi_z = z;
        end
        stored++;
        return;
      end
      r = '0;
      if (stored == 0 || next_idx >= stored) begin
        r.store_empty = 1'b1;
        due_points = {due_points, r};
        return;
      end
      if (next_idx == 0) begin
        ex = hi_x - lo_x;
        ey = hi_y - lo_y;
        ez = hi_z - lo_z;
        span = ex;
        if (ey > span) span = ey;
        if (ez > span) span = ez;
      end
      i = next_idx;
      if (span == 0) begin
        r.out_x = off_x;
        r.out_y = off_y;
        r.zero_extent = 1'b1;
      end else begin
        r.out_x = clip32(longint'(scaled(pts_x[i])) + longint'(off_x));
        r.out_y = clip32(longint'(scaled(pts_y[i])) + longint'(off_y));
        r.out_z = scaled(pts_z[i]);
      end
      if (i + 1 >= stored) begin
        r.last_point = 1'b1;
        clear_box();
      end else begin
        next_idx = i + 1;
      end
      due_points = {due_points, r};
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endfunction

    function void compare_field(string name, logic [COORD_W-1:0] got,
                                logic [COORD_W-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_points.size() == 0) begin
        report("result strobed with no fetch pending");
        return;
      end
      want = due_points.pop_front();
      compare_field("out_x", got.out_x, want.out_x);
      compare_field("out_y", got.out_y, want.out_y);
      compare_field("out_z", got.out_z, want.out_z);
      compare_field("last_point", COORD_W'(got.last_point), COORD_W'(want.last_point));
      compare_field("zero_extent", COORD_W'(got.zero_extent),
                    COORD_W'(want.zero_extent));
      compare_field("store_empty", COORD_W'(got.store_empty),
                    COORD_W'(want.store_empty));
    endfunction

    function void finish_check();
      if (due_points.size() != 0)
        report($sformatf("%0d fetch results never arrived", due_points.size()));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  item;
  logic                 done;
  out_t                 result;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [COORD_W-1:0]   wr_data;

  cloud_scoreboard board = new();
  int sent = 0;
  bit burst = 1'b0;

  point_cloud_normalizer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  task automatic send(in_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
    sent++;
  endtask

  task automatic send_load(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           logic signed [COORD_W-1:0] z);
    in_t it;
    it.kind = KIND_LOAD;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send(it);
  endtask

  task automatic send_fetch();
    in_t it;
    it.kind = KIND_FETCH;
    it.coord_x = $urandom;
    it.coord_y = $urandom;
    it.coord_z = $urandom;
    send(it);
  endtask

  // hold off until every fetch has returned and the block is idle
  task automatic settle(int tail);
    start <= 1'b0;
    while (board.due_points.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_offsets(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    wr_en <= 1'b1;
    wr_index <= REG_OFFSET_X;
    wr_data <= x;
    @(posedge clk);
    board.set_offset(REG_OFFSET_X, x);
    wr_index <= REG_OFFSET_Y;
    wr_data <= y;
    @(posedge clk);
    board.set_offset(REG_OFFSET_Y, y);
    wr_en <= 1'b0;
  endtask

  function automatic logic signed [COORD_W-1:0] pick(coord_style_t style,
                                                     logic signed [COORD_W-1:0] base);
    case (style)
      SPREAD:      return $urandom;
      NEAR_ORIGIN: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      CLUSTER:     return base + $urandom_range(0, 7);
      CORNERS: begin
        case ($urandom_range(0, 5))
          0:       return SAT_HI;
          1:       return SAT_LO;
          2:       return 32'sd0;
          3:       return 32'sd1;
          4:       return -32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
      default:     return base;
    endcase
  endfunction

  task automatic run_cloud();
    coord_style_t style;
    logic signed [COORD_W-1:0] base;
    in_t it;
    int n;
    bit broken;
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      it.kind = 1'($urandom_range(0, 1));
      it.coord_x = $urandom;
      it.coord_y = $urandom;
      it.coord_z = $urandom;
      send(it);
      return;
    end
    style = coord_style_t'($urandom_range(0, 4));
    base = $urandom;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    broken = ($urandom_range(0, 5) == 0);
    repeat (n) send_load(pick(style, base), pick(style, base), pick(style, base));
    while (board.stored != 0) begin
      if ($urandom_range(0, 7) == 0)
        send_load(pick(style, base), pick(style, base), pick(style, base));
      send_fetch();
      if (broken && $urandom_range(0, 3) == 0) break;
    end
    if ($urandom_range(0, 3) == 0) send_fetch();
    if ($urandom_range(0, 9) == 0) settle(8);
  endtask

  initial begin
    logic [COORD_W-1:0] phase_x[5];
    logic [COORD_W-1:0] phase_y[5];
    int mark;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    wr_en = 1'b0;
    wr_index = REG_OFFSET_X;
    wr_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_fetch();
    send_load(SAT_HI, SAT_LO, 32'sd0);
    send_fetch();
    send_fetch();
    send_load(SAT_HI, SAT_HI, SAT_HI);
    send_load(SAT_LO, SAT_LO, SAT_LO);
    send_fetch();
    send_fetch();
    send_load(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000);
    send_load(-32'sh0001_0000, 32'sh0003_0000, 32'sd0);
    send_load(32'sd0, 32'sd0, -32'sh0004_0000);
    send_fetch();
    send_load(32'sh0002_8000, 32'sh0001_0000, 32'sh0005_0000);
    repeat (3) send_fetch();
    settle(8);
    write_offsets(SAT_HI, SAT_HI);
    send_load(32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000);
    send_load(32'sh7FFF_0001, 32'sh7FFF_0000, 32'sh7FFF_0000);
    repeat (2) send_fetch();
    settle(8);
    write_offsets(SAT_LO, SAT_LO);
    send_load(SAT_LO, SAT_LO, SAT_LO);
    send_load(SAT_LO + 2, SAT_LO + 1, SAT_LO);
    repeat (2) send_fetch();

    phase_x = '{OFFSET_X_RESET, 32'd0, SAT_HI, SAT_LO, $urandom};
    phase_y = '{OFFSET_Y_RESET, 32'd0, SAT_LO, SAT_HI, $urandom};
    for (int p = 0; p < 5; p++) begin
      settle(8);
      write_offsets(phase_x[p], phase_y[p]);
      mark = sent;
      while (sent - mark < 340) run_cloud();
    end

    settle(100);
    board.finish_check();
    if (board.fails == 0) begin
      $display("point_cloud_normalizer test passed");
    end else begin
      $display("point_cloud_normalizer test failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("point_cloud_normalizer test failed");
    $finish;
  end

endmodule
